@@ rtl/spk_pkg.sv @@
// Shared types, codes and constants for the Speck block cipher.
// No dependencies; every other file in rtl/ imports this package.

package spk_pkg;

  // Port width of block words and key words
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RND_W     = 5;

  // Word width, rotation amounts and round count of each variant
  localparam int unsigned WIDTH_32_64  = 16;
  localparam int unsigned WIDTH_48_96  = 24;
  localparam int unsigned WIDTH_64_128 = 32;
  localparam int unsigned ALPHA_32_64  = 7;
  localparam int unsigned ALPHA_WIDE   = 8;
  localparam int unsigned BETA_32_64   = 2;
  localparam int unsigned BETA_WIDE    = 3;
  localparam logic [RND_W-1:0] ROUNDS_32_64  = 5'd22;
  localparam logic [RND_W-1:0] ROUNDS_48_96  = 5'd23;
  localparam logic [RND_W-1:0] ROUNDS_64_128 = 5'd27;

  typedef enum logic [1:0] {
    VAR_32_64  = 2'd0,
    VAR_48_96  = 2'd1,
    VAR_64_128 = 2'd2
  } variant_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VARIANT = 3'd0,
    CFG_KEY_0   = 3'd1,
    CFG_KEY_1   = 3'd2,
    CFG_KEY_2   = 3'd3,
    CFG_KEY_3   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'd0,
    ST_EXPAND = 3'd1,
    ST_IDLE   = 3'd2,
    ST_RUN    = 3'd3,
    ST_DONE   = 3'd4
  } state_e;

  // Shift command to the round-key ring
  typedef struct packed {
    logic fwd;
    logic bwd;
  } shift_t;

  // Control of the shared ARX round
  typedef struct packed {
    logic     decrypt;
    variant_e var_sel;
  } round_ctrl_t;

  function automatic logic [DATA_W-1:0] spk_mask(input variant_e v);
    logic [DATA_W-1:0] m;
    unique case (v)
      VAR_32_64: m = 32'h0000_FFFF;
      VAR_48_96: m = 32'h00FF_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [RND_W-1:0] spk_rounds(input variant_e v);
    logic [RND_W-1:0] r;
    unique case (v)
      VAR_32_64: r = ROUNDS_32_64;
      VAR_48_96: r = ROUNDS_48_96;
      default:   r = ROUNDS_64_128;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/spk_key_cell.sv @@
// One cell of the round-key ring: holds a single round key word.
// Depends on spk_pkg for the shift command type.

module spk_key_cell import spk_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  shift_t       shift_i,
  input  logic [W-1:0] fwd_i,
  input  logic [W-1:0] bwd_i,
  output logic [W-1:0] key_o
);

  logic [W-1:0] key_d, key_q;

  // Take the neighbour's word in the commanded direction, else hold
  always_comb begin
    priority if (shift_i.fwd) begin
      key_d = fwd_i;
    end else if (shift_i.bwd) begin
      key_d = bwd_i;
    end else begin
      key_d = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

@@ rtl/spk_round.sv @@
// One Speck add-rotate-xor round, forward or inverse, for all three variants.
// Depends on spk_pkg; shared by the key schedule and the block datapath.

module spk_round import spk_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  round_ctrl_t  ctrl_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] k_i,
  output logic [W-1:0] x_o,
  output logic [W-1:0] y_o
);

  // Rotate left by r within the low w bits
  function automatic logic [DATA_W-1:0] rotl(
    input logic [DATA_W-1:0] v,
    input int unsigned       r,
    input int unsigned       w
  );
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] vm;
    m  = (DATA_W'(1) << w) - DATA_W'(1);
    vm = v & m;
    return ((vm << r) | (vm >> (w - r))) & m;
  endfunction

  // Round on w-bit words; result packed as {x, y}
  function automatic logic [2*DATA_W-1:0] arx(
    input logic              dec,
    input logic [DATA_W-1:0] x,
    input logic [DATA_W-1:0] y,
    input logic [DATA_W-1:0] k,
    input int unsigned       w,
    input int unsigned       a,
    input int unsigned       b
  );
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] xr;
    logic [DATA_W-1:0] yr;
    m = (DATA_W'(1) << w) - DATA_W'(1);
    if (dec) begin
      yr = rotl(x ^ y, w - b, w);
      xr = rotl((x ^ k) - yr, a, w);
    end else begin
      xr = ((rotl(x, w - a, w) + y) ^ k) & m;
      yr = rotl(y, b, w) ^ xr;
    end
    return {xr, yr};
  endfunction

  logic [DATA_W-1:0]   xw, yw, kw;
  logic [2*DATA_W-1:0] res;

  assign xw = DATA_W'(x_i);
  assign yw = DATA_W'(y_i);
  assign kw = DATA_W'(k_i);

  // Pick the variant's width and rotation amounts
  always_comb begin
    unique case (ctrl_i.var_sel)
      VAR_32_64: res = arx(ctrl_i.decrypt, xw, yw, kw, WIDTH_32_64, ALPHA_32_64, BETA_32_64);
      VAR_48_96: res = arx(ctrl_i.decrypt, xw, yw, kw, WIDTH_48_96, ALPHA_WIDE, BETA_WIDE);
      default:   res = arx(ctrl_i.decrypt, xw, yw, kw, WIDTH_64_128, ALPHA_WIDE, BETA_WIDE);
    endcase
  end

  assign x_o = res[DATA_W +: W];
  assign y_o = res[0 +: W];

endmodule

@@ rtl/speck_block_cipher.sv @@
// Speck block cipher top level: config registers, key schedule, round-key ring
// and block datapath. Depends on spk_pkg, spk_key_cell and spk_round.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in
//   in      | in_valid_i, in_ready_o, kind_i, first/second_word | in
//   out     | out_valid_o, out_ready_i, out_first/second_word   | out
//
// With n rounds (22, 23 or 27, at most MAX_ROUNDS) a block runs its rounds after
// transfer, then hands the result from the done state to the output register;
// the next block is taken after that. The single shared ARX round unit does
// one round per cycle. After reset and each write to a known register the key
// schedule fills the key ring through the same round unit; in_ready_o is low.
// A waiting result sits in the output register while the next block is taken;
// a finished block waits in place if that register is still full.

module speck_block_cipher import spk_pkg::*; #(
  parameter int unsigned MAX_ROUNDS    = 27,
  parameter int unsigned MAX_WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [DATA_W-1:0]    first_word_i,
  input  logic [DATA_W-1:0]    second_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DATA_W-1:0]    out_first_word_o,
  output logic [DATA_W-1:0]    out_second_word_o
);

  localparam int unsigned W     = MAX_WORD_BITS;
  localparam int unsigned IDX_W = $clog2(MAX_ROUNDS);
  localparam variant_e VAR_TOP  = (W >= WIDTH_64_128) ? VAR_64_128 :
                                  (W >= WIDTH_48_96)  ? VAR_48_96  : VAR_32_64;

  // Configuration registers
  logic [1:0]        var_q;
  logic [DATA_W-1:0] key_q [4];
  logic              cfg_wr, cfg_known;

  // Control state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers
  logic [W-1:0] x_q, x_d, y_q, y_d;
  logic         kind_q, kind_d;
  logic [W-1:0] kcur_q, kcur_d;
  logic [W-1:0] l_q [3];
  logic [W-1:0] l_d [3];
  logic [W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  // Derived values
  variant_e         var_req, var_act;
  logic [RND_W-1:0] rnd_var;
  logic [IDX_W-1:0] n_m1;
  logic [W-1:0]     word_mask;

  // Round unit and key ring
  round_ctrl_t  rnd_ctrl;
  logic [W-1:0] rnd_x, rnd_y, rnd_k, rnd_x_o, rnd_y_o;
  logic [W-1:0] cell_q [MAX_ROUNDS];
  logic [W-1:0] ring_tail, run_key;
  shift_t       ring_shift;
  logic         running;

  // Fold the unused variant code and narrow builds onto a supported variant
  always_comb begin
    var_req = (var_q > 2'(VAR_64_128)) ? VAR_64_128 : variant_e'(var_q);
    var_act = (var_req > VAR_TOP) ? VAR_TOP : var_req;
    rnd_var = spk_rounds(var_act);
    if (32'(rnd_var) > MAX_ROUNDS) begin
      n_m1 = IDX_W'(MAX_ROUNDS - 1);
    end else begin
      n_m1 = IDX_W'(rnd_var - RND_W'(1));
    end
    word_mask = W'(spk_mask(var_act));
  end

  // Register writes
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    unique case (cfg_index_i)
      CFG_VARIANT, CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_q    <= 2'(VAR_64_128);
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      key_q[3] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_VARIANT: var_q    <= cfg_data_i[1:0];
        CFG_KEY_0:   key_q[0] <= cfg_data_i;
        CFG_KEY_1:   key_q[1] <= cfg_data_i;
        CFG_KEY_2:   key_q[2] <= cfg_data_i;
        CFG_KEY_3:   key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared round: key schedule step while expanding, block round while running
  assign running          = (state_q == ST_RUN);
  assign run_key          = kind_q ? cell_q[n_m1] : cell_q[0];
  assign rnd_ctrl.decrypt = running & kind_q;
  assign rnd_ctrl.var_sel = var_act;
  assign rnd_x            = running ? x_q : l_q[0];
  assign rnd_y            = running ? y_q : kcur_q;
  assign rnd_k            = running ? run_key : W'(cnt_q);

  spk_round #(
    .W (W)
  ) u_round (
    .ctrl_i (rnd_ctrl),
    .x_i    (rnd_x),
    .y_i    (rnd_y),
    .k_i    (rnd_k),
    .x_o    (rnd_x_o),
    .y_o    (rnd_y_o)
  );

  // Key ring: new keys enter at the tail while expanding, else the head wraps
  assign ring_tail = (state_q == ST_EXPAND) ? kcur_q : cell_q[0];

  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_ring
    logic [W-1:0] fwd_src, bwd_src;

    if (i == MAX_ROUNDS - 1) begin : g_last
      assign fwd_src = ring_tail;
    end else begin : g_mid
      assign fwd_src = (IDX_W'(i) == n_m1) ? ring_tail : cell_q[i+1];
    end

    if (i == 0) begin : g_head
      assign bwd_src = cell_q[n_m1];
    end else begin : g_body
      assign bwd_src = cell_q[i-1];
    end

    spk_key_cell #(
      .W (W)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (ring_shift),
      .fwd_i   (fwd_src),
      .bwd_i   (bwd_src),
      .key_o   (cell_q[i])
    );
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    y_d         = y_q;
    kind_d      = kind_q;
    kcur_d      = kcur_q;
    l_d         = l_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    ring_shift  = '0;

    unique case (state_q)
      ST_LOAD: begin
        kcur_d  = key_q[0][W-1:0] & word_mask;
        l_d[0]  = key_q[1][W-1:0] & word_mask;
        l_d[1]  = key_q[2][W-1:0] & word_mask;
        l_d[2]  = key_q[3][W-1:0] & word_mask;
        cnt_d   = '0;
        state_d = ST_EXPAND;
      end
      ST_EXPAND: begin
        ring_shift.fwd = 1'b1;
        kcur_d         = rnd_y_o;
        l_d[0]         = l_q[1];
        l_d[1]         = l_q[2];
        l_d[2]         = rnd_x_o;
        cnt_d          = cnt_q + IDX_W'(1);
        if (cnt_q == n_m1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d     = first_word_i[W-1:0] & word_mask;
          y_d     = second_word_i[W-1:0] & word_mask;
          kind_d  = kind_i;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        ring_shift.fwd = ~kind_q;
        ring_shift.bwd = kind_q;
        x_d            = rnd_x_o;
        y_d            = rnd_y_o;
        cnt_d          = cnt_q + IDX_W'(1);
        if (cnt_q == n_m1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_x_d     = x_q;
          out_y_d     = y_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_LOAD;
    endcase

    // Any write to a known register rebuilds the round keys
    if (cfg_wr && cfg_known) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    kind_q  <= kind_d;
    kcur_q  <= kcur_d;
    l_q     <= l_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
  end

  // Ports
  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign out_first_word_o  = DATA_W'(out_x_q);
  assign out_second_word_o = DATA_W'(out_y_q);

  // The ring is back home (first round key at the head) between blocks
  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |->
      (cell_q[0] == (key_q[0][W-1:0] & word_mask)))
    else $error("round-key ring not aligned to first round key");

  // Round counter never passes the last round of the variant
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_EXPAND) |-> (cnt_q <= n_m1))
    else $error("round counter beyond last round");

  // Results carry no bits above the word width
  a_out_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (((out_first_word_o | out_second_word_o)
                      & ~DATA_W'(word_mask)) == '0))
    else $error("result has bits above the word width");

  // A result only appears on hand-off from a finished block
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised without a finished block");

endmodule

@@ dv/speck_block_cipher_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the Speck block cipher: tracks register writes, keeps its own round keys,
// predicts every accepted block and compares the results in order. Depends on spk_pkg.

module speck_block_cipher_checker import spk_pkg::*; #(
  parameter int unsigned MAX_ROUNDS    = 27,
  parameter int unsigned MAX_WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 kind_i,
  input  logic [DATA_W-1:0]    first_word_i,
  input  logic [DATA_W-1:0]    second_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DATA_W-1:0]    out_first_word_i,
  input  logic [DATA_W-1:0]    out_second_word_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  typedef logic [MAX_ROUNDS-1:0][DATA_W-1:0] round_keys_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } block_t;

  // Word geometry of each variant
  function automatic int unsigned word_bits(input variant_e v);
    case (v)
      VAR_32_64: return WIDTH_32_64;
      VAR_48_96: return WIDTH_48_96;
      default:   return WIDTH_64_128;
    endcase
  endfunction

  function automatic int unsigned rot_a(input variant_e v);
    return (v == VAR_32_64) ? ALPHA_32_64 : ALPHA_WIDE;
  endfunction

  function automatic int unsigned rot_b(input variant_e v);
    return (v == VAR_32_64) ? BETA_32_64 : BETA_WIDE;
  endfunction

  function automatic int unsigned round_count(input variant_e v);
    int unsigned n;
    case (v)
      VAR_32_64: n = ROUNDS_32_64;
      VAR_48_96: n = ROUNDS_48_96;
      default:   n = ROUNDS_64_128;
    endcase
    return (n > MAX_ROUNDS) ? MAX_ROUNDS : n;
  endfunction

  // Map the register code onto a variant the build supports
  function automatic variant_e active_variant(input logic [1:0] sel);
    variant_e v;
    v = (sel > VAR_64_128) ? VAR_64_128 : variant_e'(sel);
    while (v != VAR_32_64 && word_bits(v) > MAX_WORD_BITS) v = variant_e'(v - 1'b1);
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] word_mask(input int unsigned w);
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    return m[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] rot_left(input logic [DATA_W-1:0] x,
                                                 input int unsigned r, input int unsigned w);
    logic [63:0] v;
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    v = {32'd0, x} & m;
    v = ((v << r) | (v >> (w - r))) & m;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] rot_right(input logic [DATA_W-1:0] x,
                                                  input int unsigned r, input int unsigned w);
    return rot_left(x, w - r, w);
  endfunction

  // Speck key schedule from the four key words
  function automatic round_keys_t expand_schedule(input logic [1:0] sel,
                                                  input logic [DATA_W-1:0] k0,
                                                  input logic [DATA_W-1:0] k1,
                                                  input logic [DATA_W-1:0] k2,
                                                  input logic [DATA_W-1:0] k3);
    variant_e          v;
    int unsigned       w, a, b, n, i;
    logic [DATA_W-1:0] m, l0, l1, l2, nl, idx;
    round_keys_t       rk;
    v  = active_variant(sel);
    w  = word_bits(v);
    a  = rot_a(v);
    b  = rot_b(v);
    n  = round_count(v);
    m  = word_mask(w);
    l0 = k1 & m;
    l1 = k2 & m;
    l2 = k3 & m;
    rk = '0;
    rk[0] = k0 & m;
    for (i = 0; i + 1 < n; i++) begin
      idx = i;
      nl = ((rot_right(l0, a, w) + rk[i]) ^ idx) & m;
      rk[i+1] = rot_left(rk[i], b, w) ^ nl;
      l0 = l1;
      l1 = l2;
      l2 = nl;
    end
    return rk;
  endfunction

  // Encrypt or decrypt one block under the current round keys
  function automatic block_t crypt_block(input logic decrypt, input logic [DATA_W-1:0] x_in,
                                         input logic [DATA_W-1:0] y_in, input logic [1:0] sel,
                                         input round_keys_t rk);
    variant_e          v;
    int unsigned       w, a, b, n, i;
    logic [DATA_W-1:0] m, x, y;
    block_t            res;
    v = active_variant(sel);
    w = word_bits(v);
    a = rot_a(v);
    b = rot_b(v);
    n = round_count(v);
    m = word_mask(w);
    x = x_in & m;
    y = y_in & m;
    if (!decrypt) begin
      for (i = 0; i < n; i++) begin
        x = ((rot_right(x, a, w) + y) ^ rk[i]) & m;
        y = rot_left(y, b, w) ^ x;
      end
    end else begin
      for (i = n; i > 0; i--) begin
        y = rot_right(x ^ y, b, w);
        x = rot_left(((x ^ rk[i-1]) - y) & m, a, w);
      end
    end
    res.x = x & m;
    res.y = y & m;
    return res;
  endfunction

  logic [1:0]        sel_variant;
  logic [DATA_W-1:0] key_word [4];
  round_keys_t       round_keys;
  block_t            expected_blocks [$];
  int                errors = 0;

  always @(posedge clk_i or negedge rst_ni) begin : track
    block_t want;
    if (!rst_ni) begin
      // Reset settings: widest variant, all-zero key
      sel_variant = VAR_64_128;
      key_word    = '{default: '0};
      round_keys  = expand_schedule(sel_variant, key_word[0], key_word[1], key_word[2],
                                    key_word[3]);
      expected_blocks.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      // Compare a result transfer with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_blocks.size() == 0) begin
          $error("result transfer with no block outstanding: %h %h",
                 out_first_word_i, out_second_word_i);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_first_word_i !== want.x) begin
            $error("out_first_word: expected %h, actual %h", want.x, out_first_word_i);
            errors++;
          end
          if (out_second_word_i !== want.y) begin
            $error("out_second_word: expected %h, actual %h", want.y, out_second_word_i);
            errors++;
          end
        end
      end
      // Register write: update the copy and rebuild the round keys
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_VARIANT: sel_variant = cfg_data_i[1:0];
          CFG_KEY_0:   key_word[0] = cfg_data_i;
          CFG_KEY_1:   key_word[1] = cfg_data_i;
          CFG_KEY_2:   key_word[2] = cfg_data_i;
          CFG_KEY_3:   key_word[3] = cfg_data_i;
          default:     ;
        endcase
        round_keys = expand_schedule(sel_variant, key_word[0], key_word[1], key_word[2],
                                     key_word[3]);
      end
      // Block transfer: predict its result
      if (in_valid_i && in_ready_i) begin
        expected_blocks.push_back(crypt_block(kind_i, first_word_i, second_word_i,
                                              sel_variant, round_keys));
      end
      pending_o    <= expected_blocks.size();
      fail_count_o <= errors;
    end
  end

endmodule

@@ dv/speck_block_cipher_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the Speck block cipher: clock, reset, register writes, block stimulus
// and output back-pressure. Depends on spk_pkg, speck_block_cipher and its checker.

module speck_block_cipher_tb import spk_pkg::*; ();

  localparam int unsigned MAX_ROUNDS    = 27;
  localparam int unsigned MAX_WORD_BITS = 32;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  // Variant code with no variant of its own, and indexes with no register
  localparam logic [1:0]           VAR_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [DATA_W-1:0]    cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 kind_i        = 1'b0;
  logic [DATA_W-1:0]    first_word_i  = '0;
  logic [DATA_W-1:0]    second_word_i = '0;
  logic                 out_ready_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [DATA_W-1:0]    out_first_word_o;
  logic [DATA_W-1:0]    out_second_word_o;

  int blocks_in_flight;
  int mismatches;
  bit calm = 1'b0;

  speck_block_cipher #(
    .MAX_ROUNDS   (MAX_ROUNDS),
    .MAX_WORD_BITS(MAX_WORD_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .first_word_i     (first_word_i),
    .second_word_i    (second_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_first_word_o (out_first_word_o),
    .out_second_word_o(out_second_word_o)
  );

  speck_block_cipher_checker #(
    .MAX_ROUNDS   (MAX_ROUNDS),
    .MAX_WORD_BITS(MAX_WORD_BITS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (kind_i),
    .first_word_i     (first_word_i),
    .second_word_i    (second_word_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_first_word_i (out_first_word_o),
    .out_second_word_i(out_second_word_o),
    .pending_o        (blocks_in_flight),
    .fail_count_o     (mismatches)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly random words, now and then all zeros or all ones
  function automatic logic [DATA_W-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom();
  endfunction

  // Variant code in the low bits, noise above
  function automatic logic [DATA_W-1:0] variant_data(input logic [1:0] sel);
    logic [DATA_W-1:0] d;
    d = $urandom();
    d[1:0] = sel;
    return d;
  endfunction

  // Hold one register write until its transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Offer one block, after an optional gap, and hold it until its transfer
  task automatic send_block(input logic k, input logic [DATA_W-1:0] x,
                            input logic [DATA_W-1:0] y);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    first_word_i  <= x;
    second_word_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (blocks_in_flight != 0);
  endtask

  // Output back-pressure in random bursts, none in the calm part
  initial begin : sink
    int unsigned stall;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL speck_block_cipher");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]        dir_sel [4];
    logic [DATA_W-1:0] key_fill;
    int unsigned       phase, item, j;
    dir_sel = '{VAR_32_64, VAR_48_96, VAR_64_128, VAR_UNUSED};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: 64/128 under an all-zero key
    send_block(KIND_ENCRYPT, '0, '0);
    send_block(KIND_DECRYPT, '0, '0);
    send_block(KIND_ENCRYPT, '1, '1);

    // Each variant code, the unused one too, with extreme and random keys
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_reg(CFG_VARIANT, variant_data(dir_sel[phase]));
      if (phase[0]) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom());
      end
      for (j = 0; j < 4; j++) begin
        case (phase)
          0:       key_fill = '1;
          2:       key_fill = '0;
          default: key_fill = $urandom();
        endcase
        write_reg(cfg_reg_e'(CFG_KEY_0 + j), key_fill);
      end
      cfg_valid_i <= 1'b0;
      // Full-width words also check that the upper bits are cut off
      send_block(KIND_ENCRYPT, '0, '0);
      send_block(KIND_ENCRYPT, '1, '1);
      send_block(KIND_DECRYPT, '1, '1);
      send_block(KIND_DECRYPT, $urandom(), $urandom());
      send_block(KIND_ENCRYPT, $urandom(), $urandom());
    end

    // Random phases with random register writes; the last one without idling
    for (phase = 0; phase < 8; phase++) begin
      wait_drained();
      if (phase == 7) calm = 1'b1;
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        write_reg(CFG_VARIANT, variant_data(2'($urandom_range(0, 3))));
      end
      for (j = 0; j < 4; j++) begin
        if ($urandom_range(0, 1) == 1) write_reg(cfg_reg_e'(CFG_KEY_0 + j), random_word());
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom());
      end
      cfg_valid_i <= 1'b0;
      for (item = 0; item < 50; item++) begin
        // Hold off the sender once until the pipe is empty
        if (phase == 3 && item == 25) wait_drained();
        send_block(1'($urandom_range(0, 1)), random_word(), random_word());
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS speck_block_cipher");
    end else begin
      $display("FAIL speck_block_cipher");
    end
    $finish;
  end

endmodule
